/* hdl/spa_pkg.sv */
// shared types, constants and helpers of the server pool allocator
`timescale 1ns / 1ps

package spa_pkg;

  // pool and client table sizes; both stay powers of two so pointers wrap by truncation
  localparam int MAX_SERVERS = 16;
  localparam int MAX_CLIENTS = 64;

  localparam int SRV_W  = $clog2(MAX_SERVERS);
  localparam int CLI_W  = $clog2(MAX_CLIENTS);
  localparam int SCNT_W = $clog2(MAX_SERVERS + 1);
  localparam int CCNT_W = $clog2(MAX_CLIENTS + 1);
  localparam int CFG_W  = (SCNT_W > CCNT_W) ? SCNT_W : CCNT_W;

  // register indexes
  localparam logic CFG_SERVER_COUNT = 1'b0;
  localparam logic CFG_CLIENT_COUNT = 1'b1;

  // operations
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_FINISH  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_FORWARDED = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;
  localparam logic [2:0] ST_BAD       = 3'd6;

  typedef struct packed {
    logic             holds;
    logic             waiting;
    logic [SRV_W-1:0] held;
  } cli_entry_t;

  typedef struct packed {
    logic             en;
    logic [CLI_W-1:0] addr;
    cli_entry_t       data;
  } cli_wr_t;

  typedef struct packed {
    logic              restart;
    logic [SCNT_W-1:0] fill;
    logic              take;
    logic              put;
    logic [SRV_W-1:0]  put_srv;
  } pool_ctl_t;

  typedef struct packed {
    logic             restart;
    logic             push;
    logic [CLI_W-1:0] push_cid;
    logic             pop;
  } wq_ctl_t;

  function automatic logic [SCNT_W-1:0] sat_servers(input logic [SCNT_W-1:0] v);
    return (v > SCNT_W'(MAX_SERVERS)) ? SCNT_W'(MAX_SERVERS) : v;
  endfunction

  function automatic logic [CCNT_W-1:0] sat_clients(input logic [CCNT_W-1:0] v);
    return (v > CCNT_W'(MAX_CLIENTS)) ? CCNT_W'(MAX_CLIENTS) : v;
  endfunction

endpackage

/* hdl/spa_free_pool.sv */
// free server pool: circular memory with head pointer, fill count and per-entry valid bits
`timescale 1ns / 1ps

module spa_free_pool import spa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pool_ctl_t         ctl,
  input  logic              rd_en,
  output logic [SRV_W-1:0]  head_srv,
  output logic [SCNT_W-1:0] count
);

  logic [SRV_W-1:0]       mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld;
  logic [SRV_W-1:0]       head;
  logic [SRV_W-1:0]       tail;
  logic                   put_ok;

  assign tail   = head + count[SRV_W-1:0];
  assign put_ok = ctl.put && (count < SCNT_W'(MAX_SERVERS));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= SCNT_W'(MAX_SERVERS);
      vld   <= '0;
    end else if (ctl.restart) begin
      head  <= '0;
      count <= ctl.fill;
      vld   <= '0;
    end else if (ctl.take) begin
      head  <= head + SRV_W'(1);
      count <= count - SCNT_W'(1);
    end else if (put_ok) begin
      count     <= count + SCNT_W'(1);
      vld[tail] <= 1'b1;
    end
  end

  // an entry never written since restart reads as its own index
  always_ff @(posedge clk) begin
    if (put_ok && !ctl.restart) begin
      mem[tail] <= ctl.put_srv;
    end
    if (rd_en) begin
      head_srv <= vld[head] ? mem[head] : head;
    end
  end

endmodule

/* hdl/spa_wait_queue.sv */
// fifo waitlist of client ids kept in a circular memory
`timescale 1ns / 1ps

module spa_wait_queue import spa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  wq_ctl_t           ctl,
  input  logic              rd_en,
  output logic [CLI_W-1:0]  head_cid,
  output logic [CCNT_W-1:0] count
);

  logic [CLI_W-1:0] mem [MAX_CLIENTS];
  logic [CLI_W-1:0] head;
  logic [CLI_W-1:0] tail;
  logic             push_ok;

  assign tail    = head + count[CLI_W-1:0];
  assign push_ok = ctl.push && (count < CCNT_W'(MAX_CLIENTS));

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.pop) begin
      head  <= head + CLI_W'(1);
      count <= count - CCNT_W'(1);
    end else if (push_ok) begin
      count <= count + CCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok && !ctl.restart) begin
      mem[tail] <= ctl.push_cid;
    end
    if (rd_en) begin
      head_cid <= mem[head];
    end
  end

endmodule

/* hdl/spa_client_table.sv */
// per-client memory of holder and waiting marks and held server, with valid bits
`timescale 1ns / 1ps

module spa_client_table import spa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             rd_en,
  input  logic [CLI_W-1:0] rd_addr,
  output cli_entry_t       rd_data,
  input  cli_wr_t          wr
);

  cli_entry_t             mem [MAX_CLIENTS];
  logic [MAX_CLIENTS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // untouched entries read as cleared marks
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

/* hdl/server_pool_allocator_with_waitlist_unit.sv */
// top level: server pool allocator with fifo waitlist
`timescale 1ns / 1ps

// Lends servers from a fifo free pool to clients. Each input word (operation, client_id)
// yields one result word, or two for a finish that returns a server while clients wait:
// a release word with last low, then a grant word to the oldest waiting client. One item is
// handled at a time: the accept cycle issues reads of the client table, the pool head and
// the waitlist head (synchronous memories), and S_EXEC then does the read-modify-write and
// loads the output register once that register is free; S_SECOND issues a second grant
// word when one follows, again waiting for a free output register. The
// output register lets the next item be accepted while the last word still waits. A write
// on the configuration port (index 0 server_count, 1 client_count, saturated at 16 and 64)
// restarts the pool and clears all marks in the same cycle; no clearing pass is needed, as
// valid bits cover the client table and the pool. Write configuration only while idle.
module server_pool_allocator_with_waitlist_unit import spa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [CLI_W-1:0]  client_id,
  // output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [CLI_W-1:0]  client_out,
  output logic [SRV_W-1:0]  server_id,
  output logic              last,
  // configuration port
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SECOND
  } state_t;

  state_t             state;
  logic               op_q;
  logic [CLI_W-1:0]   cid_q;
  logic [SRV_W-1:0]   grant_srv;
  logic [SRV_W-1:0]   grant_next;
  logic [SCNT_W-1:0]  srv_cnt;
  logic [CCNT_W-1:0]  cli_cnt;
  logic [SCNT_W-1:0]  fill_n;

  logic               accept;
  logic               out_free;
  logic               bad;
  logic               go_second;

  // result word being built
  logic               res_load;
  logic [2:0]         res_status;
  logic [CLI_W-1:0]   res_client;
  logic [SRV_W-1:0]   res_server;
  logic               res_last;

  // memory ports
  cli_entry_t         ent;
  cli_wr_t            cli_wr;
  pool_ctl_t          pool_ctl;
  wq_ctl_t            wq_ctl;
  logic [SRV_W-1:0]   pool_head;
  logic [SCNT_W-1:0]  fp_count;
  logic [CLI_W-1:0]   wq_head;
  logic [CCNT_W-1:0]  wq_count;
  logic [SCNT_W-1:0]  fp_after_put;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign bad      = (CCNT_W'(cid_q) >= cli_cnt);

  // pool fill used by a restart in this cycle
  assign fill_n = (cfg_index == CFG_SERVER_COUNT) ? sat_servers(cfg_data[SCNT_W-1:0]) : srv_cnt;

  // pool level once the returned server is back (a full pool drops it)
  assign fp_after_put = (fp_count < SCNT_W'(MAX_SERVERS)) ? fp_count + SCNT_W'(1) : fp_count;

  spa_client_table u_cli (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .rd_en   (accept),
    .rd_addr (client_id),
    .rd_data (ent),
    .wr      (cli_wr)
  );

  spa_free_pool u_pool (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pool_ctl),
    .rd_en    (accept),
    .head_srv (pool_head),
    .count    (fp_count)
  );

  spa_wait_queue u_wq (
    .clk      (clk),
    .rst      (rst),
    .ctl      (wq_ctl),
    .rd_en    (accept),
    .head_cid (wq_head),
    .count    (wq_count)
  );

  // decision and memory updates for the item in flight
  always_comb begin
    cli_wr           = '0;
    pool_ctl         = '0;
    pool_ctl.restart = cfg_write;
    pool_ctl.fill    = fill_n;
    wq_ctl           = '0;
    wq_ctl.restart   = cfg_write;
    res_load         = 1'b0;
    res_status       = ST_BAD;
    res_client       = cid_q;
    res_server       = '0;
    res_last         = 1'b1;
    go_second        = 1'b0;
    grant_next       = grant_srv;
    case (state)
      S_EXEC: begin
        if (out_free) begin
          res_load = 1'b1;
          if (bad) begin
            res_status = ST_BAD;
          end else if (op_q == OP_REQUEST) begin
            if (ent.holds) begin
              res_status = ST_FORWARDED;
              res_server = ent.held;
            end else if (ent.waiting) begin
              res_status = ST_DROPPED;
            end else if (fp_count != '0) begin
              // grant the head free server
              res_status   = ST_GRANTED;
              res_server   = pool_head;
              pool_ctl.take = 1'b1;
              cli_wr.en    = 1'b1;
              cli_wr.addr  = cid_q;
              cli_wr.data  = '{holds: 1'b1, waiting: 1'b0, held: pool_head};
            end else begin
              // pool empty: join the waitlist unless it is full
              res_status = ST_QUEUED;
              if (wq_count < CCNT_W'(MAX_CLIENTS)) begin
                wq_ctl.push     = 1'b1;
                wq_ctl.push_cid = cid_q;
                cli_wr.en       = 1'b1;
                cli_wr.addr     = cid_q;
                cli_wr.data     = '{holds: 1'b0, waiting: 1'b1, held: ent.held};
              end
            end
          end else if (!ent.holds) begin
            res_status = ST_IGNORED;
          end else begin
            // release: return server to the pool tail
            res_status       = ST_RELEASED;
            res_server       = ent.held;
            pool_ctl.put     = 1'b1;
            pool_ctl.put_srv = ent.held;
            cli_wr.en        = 1'b1;
            cli_wr.addr      = cid_q;
            cli_wr.data      = '{holds: 1'b0, waiting: ent.waiting, held: ent.held};
            if (wq_count != '0 && fp_after_put != '0) begin
              res_last  = 1'b0;
              go_second = 1'b1;
              // an empty pool's new head is the server just returned
              grant_next = (fp_count == '0) ? ent.held : pool_head;
            end
          end
        end
      end
      S_SECOND: begin
        if (out_free) begin
          // hand the head free server to the oldest waiter
          res_load      = 1'b1;
          res_status    = ST_GRANTED;
          res_client    = wq_head;
          res_server    = grant_srv;
          wq_ctl.pop    = 1'b1;
          pool_ctl.take = 1'b1;
          cli_wr.en     = 1'b1;
          cli_wr.addr   = wq_head;
          cli_wr.data   = '{holds: 1'b1, waiting: 1'b0, held: grant_srv};
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      srv_cnt    <= SCNT_W'(MAX_SERVERS);
      cli_cnt    <= CCNT_W'(MAX_CLIENTS);
      op_q       <= OP_REQUEST;
      cid_q      <= '0;
      grant_srv  <= '0;
      status     <= ST_GRANTED;
      client_out <= '0;
      server_id  <= '0;
      last       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SERVER_COUNT: srv_cnt <= sat_servers(cfg_data[SCNT_W-1:0]);
          CFG_CLIENT_COUNT: cli_cnt <= sat_clients(cfg_data[CCNT_W-1:0]);
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= operation;
            cid_q <= client_id;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            grant_srv <= grant_next;
            state     <= go_second ? S_SECOND : S_IDLE;
          end
        end
        S_SECOND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res_load) begin
        out_valid  <= 1'b1;
        status     <= res_status;
        client_out <= res_client;
        server_id  <= res_server;
        last       <= res_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a non-final word is only ever the release before a second grant
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_RELEASED)
    else $error("non-final word that is not a release");

  // the second grant always has a waiter to serve
  assert property (@(posedge clk) disable iff (rst)
    state == S_SECOND |-> wq_count != '0)
    else $error("second grant with empty waitlist");

  // between items, waiters exist only while the pool is empty
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && wq_count != '0 |-> fp_count == '0)
    else $error("clients waiting while servers are free");

  // the pool never holds more servers than it has places
  assert property (@(posedge clk) disable iff (rst)
    fp_count <= SCNT_W'(MAX_SERVERS))
    else $error("free pool count overflow");

endmodule

/* tb/tb.sv */
// testbench of the server pool allocator: self-checking scoreboard, drivers and monitor
`timescale 1ns / 1ps

module tb;
  import spa_pkg::*;

  // one result word as the block presents it
  typedef struct packed {
    logic [2:0]       status;
    logic [CLI_W-1:0] client;
    logic [SRV_W-1:0] server;
    logic             last;
  } result_t;

  // tracks pool, waitlist and client marks, and queues the result words each
  // accepted input word must produce
  class pool_scoreboard;
    int unsigned errors;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned handoffs;
    int unsigned seen [8];

    logic [SCNT_W-1:0] servers;
    logic [CCNT_W-1:0] clients;

    logic [SRV_W-1:0]  pool [MAX_SERVERS];
    logic [SRV_W-1:0]  pool_head;
    logic [SCNT_W-1:0] pool_fill;
    logic [CLI_W-1:0]  waitlist [MAX_CLIENTS];
    logic [CLI_W-1:0]  wait_head;
    logic [CCNT_W-1:0] wait_fill;
    bit                holding [MAX_CLIENTS];
    logic [SRV_W-1:0]  held [MAX_CLIENTS];
    bit                waiting [MAX_CLIENTS];

    result_t expected_q [$];

    function new();
      servers = SCNT_W'(MAX_SERVERS);
      clients = CCNT_W'(MAX_CLIENTS);
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < MAX_SERVERS; i++)
        pool[i] = (i < servers) ? SRV_W'(i) : '0;
      pool_head = '0;
      pool_fill = servers;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        waitlist[i] = '0;
        holding[i]  = 1'b0;
        held[i]     = '0;
        waiting[i]  = 1'b0;
      end
      wait_head = '0;
      wait_fill = '0;
    endfunction

    function void configure(logic idx, logic [CFG_W-1:0] data);
      logic [SCNT_W-1:0] sv;
      logic [CCNT_W-1:0] cv;
      sv = data[SCNT_W-1:0];
      cv = data[CCNT_W-1:0];
      if (idx == CFG_SERVER_COUNT)
        servers = (sv > MAX_SERVERS) ? SCNT_W'(MAX_SERVERS) : sv;
      else
        clients = (cv > MAX_CLIENTS) ? CCNT_W'(MAX_CLIENTS) : cv;
      restart();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void expect_word(logic [2:0] st, logic [CLI_W-1:0] c, logic [SRV_W-1:0] s,
                              logic lst);
      result_t w;
      w.status = st;
      w.client = c;
      w.server = s;
      w.last   = lst;
      expected_q.push_back(w);
    endfunction

    function logic [SRV_W-1:0] pool_take();
      logic [SRV_W-1:0] s;
      s = pool[pool_head];
      pool_head = pool_head + 1'b1;
      pool_fill = pool_fill - 1'b1;
      return s;
    endfunction

    function void pool_put(logic [SRV_W-1:0] s);
      if (pool_fill >= MAX_SERVERS)
        return;
      pool[SRV_W'(pool_head + pool_fill)] = s;
      pool_fill = pool_fill + 1'b1;
    endfunction

    // accepted input word: update state and queue its results
    function void note_word(logic op, logic [CLI_W-1:0] c);
      logic [SRV_W-1:0] s;
      logic [SRV_W-1:0] g;
      logic [CLI_W-1:0] w;
      words_in++;
      if (c >= clients) begin
        expect_word(ST_BAD, c, '0, 1'b1);
      end else if (op == OP_REQUEST) begin
        if (holding[c]) begin
          expect_word(ST_FORWARDED, c, held[c], 1'b1);
        end else if (waiting[c]) begin
          expect_word(ST_DROPPED, c, '0, 1'b1);
        end else if (pool_fill > 0) begin
          s = pool_take();
          holding[c] = 1'b1;
          held[c] = s;
          expect_word(ST_GRANTED, c, s, 1'b1);
        end else begin
          if (wait_fill < MAX_CLIENTS) begin
            waitlist[CLI_W'(wait_head + wait_fill)] = c;
            wait_fill = wait_fill + 1'b1;
            waiting[c] = 1'b1;
          end
          expect_word(ST_QUEUED, c, '0, 1'b1);
        end
      end else if (!holding[c]) begin
        expect_word(ST_IGNORED, c, '0, 1'b1);
      end else begin
        s = held[c];
        holding[c] = 1'b0;
        pool_put(s);
        if (wait_fill > 0 && pool_fill > 0) begin
          // returned server goes to the tail, the head one to the oldest waiter
          w = waitlist[wait_head];
          wait_head = wait_head + 1'b1;
          wait_fill = wait_fill - 1'b1;
          waiting[w] = 1'b0;
          g = pool_take();
          holding[w] = 1'b1;
          held[w] = g;
          handoffs++;
          expect_word(ST_RELEASED, c, s, 1'b0);
          expect_word(ST_GRANTED, w, g, 1'b1);
        end else begin
          expect_word(ST_RELEASED, c, s, 1'b1);
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40)
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_word(result_t got);
      result_t want;
      words_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word status %0d client %0d server %0d last %0d",
                         got.status, got.client, got.server, got.last));
        return;
      end
      want = expected_q.pop_front();
      seen[want.status]++;
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d (client %0d)", got.status, want.status,
                         want.client));
      if (got.client !== want.client)
        report($sformatf("client_out %0d, want %0d", got.client, want.client));
      if (got.server !== want.server)
        report($sformatf("server_id %0d, want %0d (client %0d)", got.server, want.server,
                         want.client));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d (client %0d)", got.last, want.last,
                         want.client));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic             operation;
  logic [CLI_W-1:0] client_id;
  logic             out_valid;
  logic             out_ready;
  logic [2:0]       status;
  logic [CLI_W-1:0] client_out;
  logic [SRV_W-1:0] server_id;
  logic             last;
  logic             cfg_write;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pool_scoreboard sb;

  // stall controls: no_stall for sender and receiver, hold_req for the receiver
  bit no_stall;
  int hold_req;

  // register settings of the random phases: server_count, client_count
  int phase_sc [8] = '{3, 1, 16, 7, 0, 31, 2, 16};
  int phase_cc [8] = '{8, 1, 64, 20, 6, 127, 40, 17};
  int settings_done;

  server_pool_allocator_with_waitlist_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .client_id  (client_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .client_out (client_out),
    .server_id  (server_id),
    .last       (last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // offer one word from the falling edge and hold it until accepted
  task automatic send_word(input logic op, input logic [CLI_W-1:0] cid);
    @(negedge clk);
    in_valid  = 1'b1;
    operation = op;
    client_id = cid;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sb.note_word(op, cid);
  endtask

  // random sender gaps: each further idle cycle is drawn with a chance of 31 in a hundred
  task automatic sender_gap();
    while (!no_stall && $urandom_range(99) < 31) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // stop offering and wait until every expected word has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(value);
    @(posedge clk);
    sb.configure(idx, CFG_W'(value));
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // both registers, written only with the block drained
  task automatic set_pool(input int servers, input int clients);
    wait_idle();
    write_reg(CFG_SERVER_COUNT, servers);
    write_reg(CFG_CLIENT_COUNT, clients);
    settings_done++;
  endtask

  // receiver: random stalls, or a long counted hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ready = 1'b0;
        hold_req--;
      end else begin
        out_ready = no_stall || ($urandom_range(99) >= 31);
      end
    end
  end

  // monitor: every accepted result word goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(result_t'{status, client_out, server_id, last});
  end

  // run limit
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int span;
    logic op;
    logic [CLI_W-1:0] cid;

    sb = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_REQUEST;
    client_id = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_SERVER_COUNT;
    cfg_data  = '0;
    no_stall  = 1'b0;
    hold_req  = 0;
    settings_done = 1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults: grant, forward, release, finish without server, top client id
    send_word(OP_REQUEST, 6'd0);
    send_word(OP_REQUEST, 6'd0);
    send_word(OP_FINISH, 6'd0);
    send_word(OP_FINISH, 6'd0);
    send_word(OP_REQUEST, 6'd63);
    send_word(OP_FINISH, 6'd63);

    // one server, three clients: queueing, drop of a waiter, bad ids, hand-offs
    set_pool(1, 3);
    send_word(OP_REQUEST, 6'd0);
    send_word(OP_REQUEST, 6'd1);
    send_word(OP_REQUEST, 6'd1);
    send_word(OP_REQUEST, 6'd2);
    send_word(OP_FINISH, 6'd1);
    send_word(OP_REQUEST, 6'd3);
    send_word(OP_FINISH, 6'd63);
    send_word(OP_FINISH, 6'd0);
    send_word(OP_FINISH, 6'd1);
    send_word(OP_FINISH, 6'd2);

    // empty pool
    set_pool(0, 5);
    send_word(OP_REQUEST, 6'd4);
    send_word(OP_FINISH, 6'd4);

    // no valid clients, server_count above range saturates
    set_pool(31, 0);
    send_word(OP_REQUEST, 6'd0);
    send_word(OP_FINISH, 6'd42);

    // client_count above range saturates
    set_pool(16, 127);
    send_word(OP_REQUEST, 6'd21);
    send_word(OP_FINISH, 6'd21);

    // random phases: mostly request/finish pairs on a small client set that
    // contends for the pool, a little noise over all ids
    for (int p = 0; p < 8; p++) begin
      set_pool(phase_sc[p], phase_cc[p]);
      no_stall = (p == 2);
      for (int n = 0; n < 94; n++) begin
        // long receiver hold-off while the sender keeps offering
        if ((p == 3 || p == 6) && n == 5)
          hold_req = 150;
        // sender pause until everything has drained
        if (p == 4 && n == 47)
          wait_idle();
        if (sb.clients == 0 || $urandom_range(99) < 6) begin
          op  = ($urandom_range(1) == 0) ? OP_REQUEST : OP_FINISH;
          cid = CLI_W'($urandom_range(63));
        end else begin
          span = 2 * sb.servers + 3;
          if (span > sb.clients)
            span = sb.clients;
          cid = CLI_W'($urandom_range(span - 1));
          if (sb.holding[cid])
            op = ($urandom_range(99) < 60) ? OP_FINISH : OP_REQUEST;
          else
            op = ($urandom_range(99) < 85) ? OP_REQUEST : OP_FINISH;
        end
        send_word(op, cid);
        sender_gap();
      end
    end
    no_stall = 1'b0;

    // drain, then watch a little longer for stray words
    wait_idle();
    repeat (10) @(posedge clk);

    $display("run covered %0d input words and %0d result words over %0d register settings",
             sb.words_in, sb.words_out, settings_done);
    $display("grants %0d forwards %0d queued %0d dropped %0d releases %0d ignored %0d bad %0d handoffs %0d",
             sb.seen[ST_GRANTED], sb.seen[ST_FORWARDED], sb.seen[ST_QUEUED],
             sb.seen[ST_DROPPED], sb.seen[ST_RELEASED], sb.seen[ST_IGNORED],
             sb.seen[ST_BAD], sb.handoffs);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/spa_pkg.sv
hdl/spa_free_pool.sv
hdl/spa_wait_queue.sv
hdl/spa_client_table.sv
hdl/server_pool_allocator_with_waitlist_unit.sv
tb/tb.sv
